[design/ial_pkg.sv]
`timescale 1ns / 1ps

package ial_pkg;

    // request codes
    localparam logic [1:0] REQ_CALC     = 2'd0;
    localparam logic [1:0] REQ_FINISHED = 2'd1;
    localparam logic [1:0] REQ_SET_DONE = 2'd2;

    // base selection codes
    localparam logic [1:0] MODE_SMART    = 2'd0;
    localparam logic [1:0] MODE_PRECISE  = 2'd1;
    localparam logic [1:0] MODE_RELATIVE = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_START    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_TIME      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_UNBOUNDED = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_CATCHUP  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_MODE     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMART_BASE    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DAY_ONE       = 3'd7;

    // period register keeps only its low 32 bits
    localparam int PERIOD_BITS = 32;

    // status of the remainder unit towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

[design/ial_chan_if.sv]
`timescale 1ns / 1ps

interface ial_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/interval_alarm_next_time.sv]
`timescale 1ns / 1ps

// channel   direction  payload
// i_req     sink       req_type, now, finished_time
// o_res     source     next_start, reschedule, finished_valid, finished_at
// i_cfg     sink       index, value (register write, always ready)
//
// a calculate transaction that divides (now past the base, nonzero period) runs the remainder
// unit, one bit per cycle, then passes S_DIV, S_CALC and S_DONE to the result
// without a division a calculate passes S_CALC and S_DONE, a finish or set only S_DONE
// the request channel is ready only while idle, again from the cycle the result appears
// a result stalled in the output register holds the sequencer once the next one is formed
// synchronous active-low reset clears state to next 0, no last finish time

module interval_alarm_next_time #(
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ial_chan_if.sink      i_req,
    ial_chan_if.source    o_res,
    ial_chan_if.sink      i_cfg
);
    import ial_pkg::*;

    localparam logic [TIME_BITS-1:0] PERIOD_MASK =
        (TIME_BITS > PERIOD_BITS) ? TIME_BITS'({PERIOD_BITS{1'b1}}) : '1;

    typedef struct packed {
        logic [TIME_BITS-1:0] next_start;
        logic                 reschedule;
        logic                 finished_valid;
        logic [TIME_BITS-1:0] finished_at;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_CALC = 5'b00100,
        S_DONE = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    // strictly later: wrapped difference nonzero and positive
    function automatic logic later(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS-1:0] d;
        begin
            d = a - b;
            later = (d != '0) && !d[TIME_BITS-1];
        end
    endfunction

    // configuration registers
    logic [TIME_BITS-1:0] r_base_start, r_period, r_end_time, r_smart_base;
    logic                 r_end_unbounded, r_skip_catchup, r_day_one;
    logic [1:0]           r_base_mode;

    // schedule state
    logic [TIME_BITS-1:0] r_next_time, r_last_done;
    logic                 r_done_valid;

    // sequencer
    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_nt;
    logic                 r_out_valid;
    t_res                 r_res;

    logic                 w_req_acc;
    logic                 w_out_free;
    logic [TIME_BITS-1:0] w_base;
    logic                 w_div_start;
    logic [TIME_BITS-1:0] w_rem;
    t_rem_stat            w_rem_stat;
    logic [TIME_BITS-1:0] w_nt_final;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_start    <= '0;
            r_period        <= TIME_BITS'(60);
            r_end_time      <= '0;
            r_end_unbounded <= 1'b1;
            r_skip_catchup  <= 1'b0;
            r_base_mode     <= MODE_SMART;
            r_smart_base    <= '0;
            r_day_one       <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_BASE_START:    r_base_start    <= i_cfg.data.value;
                CFG_PERIOD:        r_period        <= i_cfg.data.value & PERIOD_MASK;
                CFG_END_TIME:      r_end_time      <= i_cfg.data.value;
                CFG_END_UNBOUNDED: r_end_unbounded <= i_cfg.data.value[0];
                CFG_SKIP_CATCHUP:  r_skip_catchup  <= i_cfg.data.value[0];
                CFG_BASE_MODE:     r_base_mode     <= i_cfg.data.value[1:0];
                CFG_SMART_BASE:    r_smart_base    <= i_cfg.data.value;
                CFG_DAY_ONE:       r_day_one       <= i_cfg.data.value[0];
                default: ;
            endcase
        end
    end

    // base selection: smart base, last finish time in relative mode once one is recorded, else the start time
    always_comb begin
        if (r_base_mode == MODE_SMART)
            w_base = r_smart_base;
        else if (r_base_mode == MODE_RELATIVE && r_done_valid)
            w_base = r_last_done;
        else
            w_base = r_base_start;
    end

    assign w_div_start = w_req_acc && (i_req.data.req_type == REQ_CALC)
                         && later(i_req.data.now, w_base) && (r_period != '0);

    ial_rem_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.data.now - w_base),
        .i_divisor  (r_period),
        .o_rem      (w_rem),
        .o_stat     (w_rem_stat)
    );

    // catch-up after missed ticks
    always_comb begin
        w_nt_final = r_nt;
        if (!r_skip_catchup) begin
            if (!r_done_valid) begin
                if (!r_day_one && ((r_nt - r_base_start) > r_period))
                    w_nt_final = r_now;
            end else if (later(r_nt, r_last_done) && ((r_nt - r_last_done) > r_period)) begin
                w_nt_final = r_now;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    if (w_div_start)
                        n_state = S_DIV;
                    else if (i_req.data.req_type == REQ_CALC)
                        n_state = S_CALC;
                    else
                        n_state = S_DONE;
                end
            end
            S_DIV:  if (w_rem_stat.done) n_state = S_CALC;
            S_CALC: n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
                    else n_state = S_WAIT;
            S_WAIT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state, schedule and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_time  <= '0;
            r_last_done  <= '0;
            r_done_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            // finish and set-done transactions update the last finish time
            if (w_req_acc) begin
                if (i_req.data.req_type == REQ_FINISHED) begin
                    if (later(i_req.data.now, r_base_start)) begin
                        r_last_done  <= i_req.data.now;
                        r_done_valid <= 1'b1;
                    end
                end else if (i_req.data.req_type == REQ_SET_DONE) begin
                    if (later(i_req.data.now, i_req.data.finished_time)
                        && later(i_req.data.finished_time, r_base_start)) begin
                        r_last_done  <= i_req.data.finished_time;
                        r_done_valid <= 1'b1;
                    end
                end
            end
            if (r_state == S_CALC)
                r_next_time <= w_nt_final;
            // output register: load a new result or drop the one taken
            if ((r_state == S_DONE || r_state == S_WAIT) && w_out_free)
                r_out_valid <= 1'b1;
            else if (o_res.ready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_now <= i_req.data.now;
            // no division: base itself, or now when the period is zero
            r_nt  <= later(i_req.data.now, w_base) ? i_req.data.now : w_base;
        end else if (r_state == S_DIV && w_rem_stat.done) begin
            r_nt <= r_now - w_rem + r_period;
        end
        if ((r_state == S_DONE || r_state == S_WAIT) && w_out_free) begin
            r_res.next_start     <= r_next_time;
            r_res.reschedule     <= r_end_unbounded || ((r_end_time - r_next_time) > r_period);
            r_res.finished_valid <= r_done_valid;
            r_res.finished_at    <= r_last_done;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // the sequencer waits only on a divider that is busy or done
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_rem_stat.busy || w_rem_stat.done))
        else $error("sequencer waits on an idle divider");

    // an accepted transaction always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> (r_state != S_IDLE))
        else $error("transaction accepted without leaving idle");

    // once recorded, a finish time stays recorded
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_done_valid))
        else $error("last finish time lost");

    // divider starts only from idle
    a_div_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_rem_stat.busy)
        else $error("divider restarted while busy");

endmodule

[design/ial_rem_unit.sv]
`timescale 1ns / 1ps

module ial_rem_unit #(
    parameter int TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [TIME_BITS-1:0]      i_dividend,
    input  logic [TIME_BITS-1:0]      i_divisor,
    output logic [TIME_BITS-1:0]      o_rem,
    output ial_pkg::t_rem_stat        o_stat
);
    import ial_pkg::*;

    localparam int CNT_BITS = $clog2(TIME_BITS + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [TIME_BITS-1:0] r_rem, n_rem;
    logic [TIME_BITS-1:0] r_dvd, n_dvd;
    logic [TIME_BITS-1:0] r_dvs, n_dvs;

    logic [TIME_BITS:0]   w_shift;
    logic [TIME_BITS:0]   w_trial;
    logic [TIME_BITS-1:0] w_rem_step;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_shift    = {r_rem, r_dvd[TIME_BITS-1]};
        w_trial    = w_shift - {1'b0, r_dvs};
        w_rem_step = w_trial[TIME_BITS] ? w_shift[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
    end

    // step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(TIME_BITS);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_rem_step;
            n_dvd = {r_dvd[TIME_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CNT_BITS'(1);
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    // remainder is always below the divisor once the steps are over
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

    // done and busy never overlap
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_done && r_busy))
        else $error("done while busy");

    // a run takes one restoring step per time bit; done is raised only at the end of a run
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a run");

endmodule
